/* sv/sliding_window_reorder_buffer_defines.svh */
// Assertion macros for the reorder buffer.
// SWRB_ASSERT_IMP checks cons in the same cycle as ante.
// SWRB_ASSERT_NXT checks cons in the cycle after ante.
`ifndef SLIDING_WINDOW_REORDER_BUFFER_DEFINES_SVH
`define SLIDING_WINDOW_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTH
`define SWRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SWRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SWRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/swrb_pkg.sv */
`default_nettype none

package swrb_pkg;

   // fixed field widths
   localparam int FILE_W = 24;
   localparam int SIZE_W = 11;
   localparam int BOFF_W = 10;
   localparam int BYTE_W = 8;

   typedef enum logic {
      OP_PAYLOAD = 1'b0,
      OP_DRAIN   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CS_NONE     = 2'd0,
      CS_ACCEPTED = 2'd1,
      CS_OUTSIDE  = 2'd2,
      CS_MISMATCH = 2'd3
   } chunk_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOCATE,
      S_COMMIT,
      S_DRAIN
   } state_type;

   // slot locate unit status
   typedef struct packed {
      logic done;
      logic aligned;
   } div_status_type;

endpackage

`default_nettype wire

/* sv/swrb_byte_ram.sv */
`default_nettype none

module swrb_byte_ram #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/swrb_slot_div.sv */
`default_nettype none

// Splits a window-relative offset into slot index and an aligned flag (in-chunk
// remainder is zero) by reciprocal multiply and one correction step. The offset is captured at
// start, then three register stages; done pulses as the slot and aligned flag are registered.
module swrb_slot_div #(
   parameter int CHUNK_BYTES = 1024,
   parameter int REL_W       = 15,
   parameter int SLOT_W      = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [REL_W-1:0]            rel,
   output logic [SLOT_W-1:0]           slot,
   output swrb_pkg::div_status_type    status
);

   import swrb_pkg::*;

   localparam int CW    = $clog2(CHUNK_BYTES + 1);
   localparam int MUL_W = REL_W + 1;
   localparam int PROD_W = REL_W + MUL_W;
   localparam int KC_W  = SLOT_W + CW;
   localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'(1) << REL_W) / CHUNK_BYTES);
   localparam logic [REL_W:0]   CHUNK_R = (REL_W + 1)'(CHUNK_BYTES);

   logic                v0_ff, v1_ff, v2_ff, done_ff;
   logic [REL_W-1:0]    rel0_ff, rel1_ff, rel2_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [SLOT_W-1:0]   kest_ff, slot_ff;
   logic [KC_W-1:0]     kc_ff;
   logic                aligned_ff;
   logic [REL_W:0]      rem;
   logic                fix;
   logic [REL_W:0]      rem_fixed;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff   <= start;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // estimate: quotient is kest or kest + 1
   always_ff @(posedge clock) begin
      if (start) begin
         rel0_ff <= rel;
      end
      if (v0_ff) begin
         rel1_ff <= rel0_ff;
         prod_ff <= PROD_W'(rel0_ff) * PROD_W'(RECIP);
      end
      if (v1_ff) begin
         rel2_ff <= rel1_ff;
         kest_ff <= prod_ff[REL_W +: SLOT_W];
         kc_ff   <= KC_W'(prod_ff[REL_W +: SLOT_W]) * KC_W'(CHUNK_BYTES);
      end
   end

   // correction step
   always_comb begin
      rem       = (REL_W + 1)'(rel2_ff) - (REL_W + 1)'(kc_ff);
      fix       = (rem >= CHUNK_R);
      rem_fixed = fix ? rem - CHUNK_R : rem;
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         slot_ff    <= fix ? kest_ff + SLOT_W'(1) : kest_ff;
         aligned_ff <= (rem_fixed == '0);
      end
   end

   assign slot           = slot_ff;
   assign status.done    = done_ff;
   assign status.aligned = aligned_ff;

endmodule

`default_nettype wire

/* sv/sliding_window_reorder_buffer.sv */
// Payload word: result registered after the slot divide in swrb_slot_div (offset captured
// at acceptance, then three stages), the step into commit and the commit itself; the
// next word is taken only after the commit, and a result stall delays both.
// Drain word: result registered after the registered read of the byte RAM and the commit,
// next word taken after the commit. One word is in flight at a time.
// Reset clears control state and all received flags; byte RAM is not cleared.
`default_nettype none
`include "sliding_window_reorder_buffer_defines.svh"

module sliding_window_reorder_buffer #(
   parameter int CHUNK_BYTES  = 1024,
   parameter int WINDOW_SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [swrb_pkg::FILE_W-1:0]       req_chunk_start,
   input  logic [swrb_pkg::SIZE_W-1:0]       req_chunk_size,
   input  logic [swrb_pkg::BOFF_W-1:0]       req_byte_offset,
   input  logic [swrb_pkg::BYTE_W-1:0]       req_byte_value,
   input  logic                              req_last_byte,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_out_valid,
   output logic [swrb_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [swrb_pkg::FILE_W-1:0]       rsp_out_file_offset,
   output swrb_pkg::chunk_status_type        rsp_chunk_status,
   output logic                              rsp_transfer_done,
   // total size register
   input  logic                              csr_wr_en,
   input  logic [swrb_pkg::FILE_W-1:0]       csr_wr_data
);

   import swrb_pkg::*;

   localparam int OFF_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int CW     = $clog2(CHUNK_BYTES + 1);
   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int SPAN   = WINDOW_SLOTS * CHUNK_BYTES;
   localparam int REL_W  = (SPAN > 1) ? $clog2(SPAN) : 1;
   localparam int ADDR_W = SLOT_W + OFF_W;
   localparam int DEPTH  = WINDOW_SLOTS * (2 ** OFF_W);
   localparam logic [FILE_W-1:0] SPAN_F    = FILE_W'(SPAN);
   localparam logic [FILE_W-1:0] CHUNK_F   = FILE_W'(CHUNK_BYTES);
   localparam logic [CW-1:0]     CHUNK_C   = CW'(CHUNK_BYTES);
   localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(WINDOW_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);

   // expected size of the chunk that starts at start
   function automatic logic [CW-1:0] expect_size(input logic [FILE_W-1:0] start,
                                                 input logic [FILE_W-1:0] total);
      logic [FILE_W-1:0] left;
      left = (start < total) ? total - start : '0;
      return (left < CHUNK_F) ? CW'(left) : CHUNK_C;
   endfunction

   state_type state_ff, state_in;

   logic [FILE_W-1:0]       total_ff;
   logic [SLOT_W-1:0]       head_ff;
   logic [FILE_W-1:0]       drained_ff;
   logic [OFF_W-1:0]        pos_ff;
   logic [WINDOW_SLOTS-1:0] received_ff, received_in;

   // captured item
   logic [OFF_W-1:0]  off_ff;
   logic [BYTE_W-1:0] val_ff;
   logic              last_ff;
   logic              outside_ff;
   logic              size_ok_ff;
   logic              off_ok_ff;
   logic              drain_ok_ff;
   logic [CW-1:0]     drain_size_ff;

   // output register
   logic              rsp_valid_ff;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [FILE_W-1:0] out_offset_ff;
   chunk_status_type  status_ff;
   logic              done_ff;

   logic              accept, accept_pay, accept_drain, out_free;
   logic [FILE_W-1:0] base, rel_full;
   logic              outside, size_ok, off_ok, drain_ok;
   logic [SLOT_W-1:0] div_slot;
   div_status_type    div_stat;

   logic              pay_commit, drain_commit;
   chunk_status_type  pay_status;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] phys;
   logic              ram_we, ram_re;
   logic [BYTE_W-1:0] ram_rdata;
   logic [FILE_W-1:0] drained_next;
   logic [CW-1:0]     pos_plus;
   logic              chunk_end;

   // acceptance and window checks
   always_comb begin
      accept       = req_valid && req_ready;
      accept_pay   = accept && (req_opcode == OP_PAYLOAD);
      accept_drain = accept && (req_opcode == OP_DRAIN);
      out_free     = !rsp_valid_ff || rsp_ready;
      base         = drained_ff - FILE_W'(pos_ff);
      rel_full     = req_chunk_start - base;
      outside      = (req_chunk_start < base) || (req_chunk_start >= total_ff) ||
                     (rel_full >= SPAN_F);
      size_ok      = (FILE_W'(req_chunk_size) ==
                      FILE_W'(expect_size(req_chunk_start, total_ff)));
      off_ok       = (SIZE_W'(req_byte_offset) < req_chunk_size);
      drain_ok     = (drained_ff < total_ff) && received_ff[head_ff];
   end

   swrb_slot_div #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .REL_W       (REL_W),
      .SLOT_W      (SLOT_W)
   ) u_slot_div (
      .clock  (clock),
      .reset  (reset),
      .start  (accept_pay),
      .rel    (rel_full[REL_W-1:0]),
      .slot   (div_slot),
      .status (div_stat)
   );

   // commit logic for both word kinds
   always_comb begin
      pay_commit   = (state_ff == S_COMMIT) && out_free;
      drain_commit = (state_ff == S_DRAIN) && out_free;
      if (outside_ff) begin
         pay_status = CS_OUTSIDE;
      end else if (!div_stat.aligned || !size_ok_ff || !off_ok_ff) begin
         pay_status = CS_MISMATCH;
      end else begin
         pay_status = CS_ACCEPTED;
      end
      slot_sum     = {1'b0, head_ff} + {1'b0, div_slot};
      phys         = (slot_sum >= SLOTS_X) ? SLOT_W'(slot_sum - SLOTS_X)
                                           : slot_sum[SLOT_W-1:0];
      ram_we       = pay_commit && (pay_status == CS_ACCEPTED);
      ram_re       = accept_drain && drain_ok;
      drained_next = drained_ff + FILE_W'(1);
      pos_plus     = CW'(pos_ff) + CW'(1);
      chunk_end    = (pos_plus >= drain_size_ff) || (drained_next >= total_ff);

      received_in = received_ff;
      if (ram_we && last_ff) begin
         received_in[phys] = 1'b1;
      end
      if (drain_commit && drain_ok_ff && chunk_end) begin
         received_in[head_ff] = 1'b0;
      end
   end

   swrb_byte_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (BYTE_W)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({phys, off_ff}),
      .wr_data (val_ff),
      .rd_en   (ram_re),
      .rd_addr ({head_ff, pos_ff}),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept_pay) begin
               state_in = S_LOCATE;
            end else if (accept_drain) begin
               state_in = S_DRAIN;
            end
         end
         S_LOCATE: begin
            if (div_stat.done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // window state and config register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         head_ff     <= '0;
         drained_ff  <= '0;
         pos_ff      <= '0;
         received_ff <= '0;
      end else begin
         received_ff <= received_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (drain_commit && drain_ok_ff) begin
            drained_ff <= drained_next;
            if (chunk_end) begin
               pos_ff  <= '0;
               head_ff <= (head_ff == LAST_SLOT) ? '0 : head_ff + SLOT_W'(1);
            end else begin
               pos_ff  <= OFF_W'(pos_plus);
            end
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         off_ff        <= OFF_W'(req_byte_offset);
         val_ff        <= req_byte_value;
         last_ff       <= req_last_byte;
         outside_ff    <= outside;
         size_ok_ff    <= size_ok;
         off_ok_ff     <= off_ok;
         drain_ok_ff   <= drain_ok;
         drain_size_ff <= expect_size(base, total_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pay_commit || drain_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_commit) begin
         out_valid_ff  <= 1'b0;
         out_byte_ff   <= '0;
         out_offset_ff <= '0;
         status_ff     <= pay_status;
         done_ff       <= (drained_ff >= total_ff);
      end else if (drain_commit) begin
         status_ff <= CS_NONE;
         if (drain_ok_ff) begin
            out_valid_ff  <= 1'b1;
            out_byte_ff   <= ram_rdata;
            out_offset_ff <= drained_ff;
            done_ff       <= (drained_next >= total_ff);
         end else begin
            out_valid_ff  <= 1'b0;
            out_byte_ff   <= '0;
            out_offset_ff <= '0;
            done_ff       <= (drained_ff >= total_ff);
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_valid       = out_valid_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_out_file_offset = out_offset_ff;
   assign rsp_chunk_status    = status_ff;
   assign rsp_transfer_done   = done_ff;

   // checks
   `SWRB_ASSERT_IMP(a_drain_from_received, clock, reset, (state_ff == S_DRAIN) && drain_ok_ff, received_ff[head_ff], "drain reads a slot that is not received")
   `SWRB_ASSERT_IMP(a_write_in_window, clock, reset, ram_we, !outside_ff && size_ok_ff && off_ok_ff, "byte stored for a rejected chunk")
   `SWRB_ASSERT_IMP(a_pos_in_chunk, clock, reset, 1'b1, CW'(pos_ff) < CHUNK_C, "drain position past chunk end")
   `SWRB_ASSERT_IMP(a_head_in_ring, clock, reset, 1'b1, (SLOT_W + 1)'(head_ff) < SLOTS_X, "head slot outside ring")
   `SWRB_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "sequencer idle after taking a word")

endmodule

`default_nettype wire
